>>> sv/asc_pkg.sv
// Package for the ADC spike canceller: sample classes, register indexes, helpers.
package asc_pkg;

  typedef enum logic [1:0] {
    CL_NOISE = 2'd0,
    CL_HIGH  = 2'd1,
    CL_LOW   = 2'd2,
    CL_OTHER = 2'd3
  } class_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;
  localparam int LEVEL_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_THRESH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL       = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;

  // class c closes a run of class k: noise or the opposite spike
  function automatic logic bounds(input class_t c, input class_t k);
    class_t opp;
    opp = (k == CL_HIGH) ? CL_LOW : CL_HIGH;
    return (c == CL_NOISE) || (c == opp);
  endfunction

endpackage

>>> sv/adc_spike_canceller_top.sv
// ADC spike canceller top level: classification, history, delay lines, result buffer.
// Result: the result register loads at the accepting edge, as does out_valid, unless a held
//   result sends it to the skid; it carries the sample that entered 4, 3 or 2 items before (level >=3, 2, <=1).
// Throughput: one transaction per cycle unless in_stall is high; a two-entry result buffer
//   (output register plus skid) keeps the input open while one result waits.
// Reset: synchronous active low; history to noise, delay lines to zero, registers to defaults.
module adc_spike_canceller_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  input  logic        [1:0]                    in_overload_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic        [1:0]                    out_overload_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [asc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [asc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int CmpW = (SAMPLE_BITS > asc_pkg::CFG_DATA_W) ? SAMPLE_BITS : asc_pkg::CFG_DATA_W;
  localparam logic [SAMPLE_BITS-1:0] MaxPos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  // configuration
  logic [asc_pkg::CFG_DATA_W-1:0] noise_r, noise_nxt;
  logic [asc_pkg::CFG_DATA_W-1:0] thr_r, thr_nxt;
  logic [asc_pkg::LEVEL_W-1:0]    lvl_r, lvl_nxt;

  // history and delay lines, index 0 is the first stage
  asc_pkg::class_t          h_r  [5];
  asc_pkg::class_t          h_nxt[5];
  logic [SAMPLE_BITS-1:0]   sd_r  [4];
  logic [SAMPLE_BITS-1:0]   sd_nxt[4];
  logic [1:0]               od_r  [4];
  logic [1:0]               od_nxt[4];

  // result buffer
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic [1:0]             out_ovl_r, out_ovl_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [SAMPLE_BITS-1:0] skid_sample_r, skid_sample_nxt;
  logic [1:0]             skid_ovl_r, skid_ovl_nxt;

  logic                   in_acc, out_take;
  logic [SAMPLE_BITS-1:0] mag_full, mag_sat;
  logic [CmpW-1:0]        mag_full_ext, mag_sat_ext, noise_ext, thr_ext;
  asc_pkg::class_t        cls;
  logic                   ge2, ge3, ge4;
  logic                   z_emit, z2, z1, z0;
  logic                   run_ok, run2, run3, run4;
  asc_pkg::class_t        s;
  logic [SAMPLE_BITS-1:0] emit;

  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_overload_out = out_ovl_r;
  assign cfg_ready = 1'b1;

  // classification
  always_comb begin
    mag_full = in_sample_in[SAMPLE_BITS-1] ? (~in_sample_in + 1'b1) : in_sample_in;
    mag_sat  = mag_full[SAMPLE_BITS-1] ? MaxPos : mag_full;
    mag_full_ext = CmpW'(mag_full);
    mag_sat_ext  = CmpW'(mag_sat);
    noise_ext    = CmpW'(noise_r);
    thr_ext      = CmpW'(thr_r);
    if (mag_sat_ext < noise_ext) begin
      cls = asc_pkg::CL_NOISE;
    end else if (!in_sample_in[SAMPLE_BITS-1] && (in_sample_in != '0) &&
                 (mag_full_ext < thr_ext)) begin
      cls = asc_pkg::CL_HIGH;
    end else if (in_sample_in[SAMPLE_BITS-1] && (mag_full_ext < thr_ext)) begin
      cls = asc_pkg::CL_LOW;
    end else begin
      cls = asc_pkg::CL_OTHER;
    end
  end

  // spike run detection over the history
  always_comb begin
    ge2 = (lvl_r >= asc_pkg::LEVEL_TWO);
    ge3 = (lvl_r >= asc_pkg::LEVEL_THREE);
    ge4 = (lvl_r >= asc_pkg::LEVEL_FOUR);
    z_emit = 1'b0;
    z2 = 1'b0;
    z1 = 1'b0;
    z0 = 1'b0;
    run_ok = 1'b0;
    run2 = 1'b0;
    run3 = 1'b0;
    run4 = 1'b0;
    s = asc_pkg::CL_HIGH;
    for (int k = 0; k < 2; k++) begin
      s      = (k == 0) ? asc_pkg::CL_HIGH : asc_pkg::CL_LOW;
      run_ok = asc_pkg::bounds(h_r[4], s) && (h_r[3] == s);
      run2   = ge2 && (h_r[2] == s) && asc_pkg::bounds(h_r[1], s);
      run3   = ge3 && (h_r[2] == s) && (h_r[1] == s) && asc_pkg::bounds(h_r[0], s);
      run4   = ge4 && (h_r[2] == s) && (h_r[1] == s) && (h_r[0] == s) &&
               asc_pkg::bounds(cls, s);
      if (run_ok) begin
        z_emit = z_emit || asc_pkg::bounds(h_r[2], s) || run2 || run3 || run4;
        z2     = z2 || run2 || run3 || run4;
        z1     = z1 || run3 || run4;
        z0     = z0 || run4;
      end
    end
    emit = z_emit ? '0 : sd_r[3];
  end

  // state update
  always_comb begin
    noise_nxt = noise_r;
    thr_nxt   = thr_r;
    lvl_nxt   = lvl_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        asc_pkg::REG_NOISE_LIMIT: noise_nxt = cfg_data;
        asc_pkg::REG_PEAK_THRESH: thr_nxt   = cfg_data;
        asc_pkg::REG_LEVEL:       lvl_nxt   = cfg_data[asc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end

    for (int i = 0; i < 5; i++) h_nxt[i] = h_r[i];
    for (int i = 0; i < 4; i++) begin
      sd_nxt[i] = sd_r[i];
      od_nxt[i] = od_r[i];
    end
    if (in_acc) begin
      for (int i = 1; i < 5; i++) h_nxt[i] = h_r[i-1];
      sd_nxt[3] = z2 ? '0 : sd_r[2];
      sd_nxt[2] = z1 ? '0 : sd_r[1];
      sd_nxt[1] = z0 ? '0 : sd_r[0];
      sd_nxt[0] = z0 ? '0 : sd_r[0];
      for (int i = 1; i < 4; i++) od_nxt[i] = od_r[i-1];
      if (ge3) begin
        h_nxt[0]  = cls;
        sd_nxt[0] = in_sample_in;
        od_nxt[0] = in_overload_in;
      end else if (ge2) begin
        h_nxt[1]  = cls;
        sd_nxt[1] = in_sample_in;
        od_nxt[1] = in_overload_in;
      end else begin
        h_nxt[2]  = cls;
        sd_nxt[2] = in_sample_in;
        od_nxt[2] = in_overload_in;
      end
    end
  end

  // result buffer
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_sample_nxt  = out_sample_r;
    out_ovl_nxt     = out_ovl_r;
    skid_valid_nxt  = skid_valid_r;
    skid_sample_nxt = skid_sample_r;
    skid_ovl_nxt    = skid_ovl_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = skid_sample_r;
        out_ovl_nxt    = skid_ovl_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = emit;
        out_ovl_nxt    = od_r[3];
      end else begin
        skid_valid_nxt  = 1'b1;
        skid_sample_nxt = emit;
        skid_ovl_nxt    = od_r[3];
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r      <= '0;
      thr_r        <= '0;
      lvl_r        <= asc_pkg::LEVEL_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int i = 0; i < 5; i++) h_r[i] <= asc_pkg::CL_NOISE;
      for (int i = 0; i < 4; i++) begin
        sd_r[i] <= '0;
        od_r[i] <= '0;
      end
    end else begin
      noise_r      <= noise_nxt;
      thr_r        <= thr_nxt;
      lvl_r        <= lvl_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      for (int i = 0; i < 5; i++) h_r[i] <= h_nxt[i];
      for (int i = 0; i < 4; i++) begin
        sd_r[i] <= sd_nxt[i];
        od_r[i] <= od_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r  <= out_sample_nxt;
    out_ovl_r     <= out_ovl_nxt;
    skid_sample_r <= skid_sample_nxt;
    skid_ovl_r    <= skid_ovl_nxt;
  end

endmodule

>>> sv/adc_spike_canceller_checker.sv
// Port-level checker for the ADC spike canceller, bound to the top level.
module asc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // input only stalls when a result is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // a drained output frees the input on the next cycle
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("in_stall held after output drained");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result buffer not cleared by reset");

endmodule

bind adc_spike_canceller_top asc_checker u_asc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

>>> sim/adc_spike_canceller_top_test.sv
// Testbench for adc_spike_canceller_top: directed and random streams checked by a predictor.
`timescale 1ns / 100ps

module adc_spike_canceller_top_test;

  localparam int SB = 16;
  localparam logic [asc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [asc_pkg::LEVEL_W-1:0] LEVEL_ZERO = 3'd0;
  localparam logic [asc_pkg::LEVEL_W-1:0] LEVEL_FIVE = 3'd5;
  localparam logic [asc_pkg::LEVEL_W-1:0] LEVEL_SIX  = 3'd6;
  localparam logic [asc_pkg::LEVEL_W-1:0] LEVEL_MAX  = 3'd7;
  localparam int MAX_POS = 2 ** (SB - 1) - 1;

  typedef struct {
    logic signed [SB-1:0] sample;
    logic [1:0]           tag;
  } result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic signed [SB-1:0]            in_sample_in = '0;
  logic [1:0]                      in_overload_in = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [SB-1:0]            out_sample_out;
  logic [1:0]                      out_overload_out;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [asc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [asc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  bit calm = 1'b0;
  int mismatches = 0;

  // predictor state
  asc_pkg::class_t      hist_q[5];
  logic signed [SB-1:0] sample_q[4];
  logic [1:0]           tag_q[4];
  logic [14:0]          noise_lim;
  logic [14:0]          peak_thr;
  logic [2:0]           level;
  result_t              pending_results[$];

  adc_spike_canceller_top #(.SAMPLE_BITS(SB)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_overload_in   (in_overload_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_overload_out (out_overload_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_canceller();
    for (int i = 0; i < 5; i++) hist_q[i] = asc_pkg::CL_NOISE;
    for (int i = 0; i < 4; i++) begin
      sample_q[i] = '0;
      tag_q[i] = '0;
    end
    noise_lim = '0;
    peak_thr = '0;
    level = asc_pkg::LEVEL_RESET;
  endfunction

  function automatic asc_pkg::class_t classify(input logic signed [SB-1:0] x);
    int xi;
    int mag;
    xi = int'(x);
    mag = (xi < 0) ? -xi : xi;
    if (mag > MAX_POS) mag = MAX_POS;
    if (mag < int'(noise_lim)) return asc_pkg::CL_NOISE;
    if (xi < int'(peak_thr) && xi > 0) return asc_pkg::CL_HIGH;
    if (xi > -int'(peak_thr) && xi < 0) return asc_pkg::CL_LOW;
    return asc_pkg::CL_OTHER;
  endfunction

  // noise or the opposite spike ends a run of spike class k
  function automatic bit closes_run(input asc_pkg::class_t c, input asc_pkg::class_t k);
    return c == asc_pkg::CL_NOISE ||
           c == ((k == asc_pkg::CL_HIGH) ? asc_pkg::CL_LOW : asc_pkg::CL_HIGH);
  endfunction

  function automatic result_t advance_canceller(input logic signed [SB-1:0] x,
                                                input logic [1:0] tag);
    asc_pkg::class_t c;
    asc_pkg::class_t s;
    result_t         r;
    int              lvl;
    int              k;
    c = classify(x);
    r.sample = sample_q[3];
    r.tag = tag_q[3];
    lvl = int'(level);
    for (k = 1; k <= 2; k++) begin
      s = asc_pkg::class_t'(k);
      if (closes_run(hist_q[4], s) && hist_q[3] == s) begin
        if (closes_run(hist_q[2], s)) r.sample = '0;
        if (lvl >= 2 && hist_q[2] == s && closes_run(hist_q[1], s)) begin
          r.sample = '0;
          sample_q[2] = '0;
        end
        if (lvl >= 3 && hist_q[2] == s && hist_q[1] == s && closes_run(hist_q[0], s)) begin
          r.sample = '0;
          sample_q[2] = '0;
          sample_q[1] = '0;
        end
        if (lvl >= 4 && hist_q[2] == s && hist_q[1] == s && hist_q[0] == s &&
            closes_run(c, s)) begin
          r.sample = '0;
          sample_q[2] = '0;
          sample_q[1] = '0;
          sample_q[0] = '0;
        end
      end
    end
    for (int i = 4; i >= 1; i--) hist_q[i] = hist_q[i-1];
    for (int i = 3; i >= 1; i--) begin
      sample_q[i] = sample_q[i-1];
      tag_q[i] = tag_q[i-1];
    end
    // entry stage follows the level; stages ahead of it keep shifting
    if (lvl >= 3) begin
      hist_q[0] = c;
      sample_q[0] = x;
      tag_q[0] = tag;
    end else if (lvl == 2) begin
      hist_q[1] = c;
      sample_q[1] = x;
      tag_q[1] = tag;
    end else begin
      hist_q[2] = c;
      sample_q[2] = x;
      tag_q[2] = tag;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no sample pending");
      end else begin
        want = pending_results.pop_front();
        if (out_sample_out !== want.sample)
          report_mismatch($sformatf("sample_out %0d, want %0d", out_sample_out, want.sample));
        if (out_overload_out !== want.tag)
          report_mismatch($sformatf("overload_out %0d, want %0d", out_overload_out, want.tag));
      end
    end
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
  end

  task automatic send_sample(input logic signed [SB-1:0] x, input logic [1:0] tag);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= x;
    in_overload_in <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(advance_canceller(x, tag));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // leaves cfg_valid high; callers lower it after the last write
  task automatic write_register(input logic [asc_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [asc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      asc_pkg::REG_NOISE_LIMIT: noise_lim = val;
      asc_pkg::REG_PEAK_THRESH: peak_thr = val;
      asc_pkg::REG_LEVEL:       level = val[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [14:0] nl, input logic [14:0] thr,
                                input logic [2:0] lvl, input logic [11:0] pad);
    wait_idle();
    write_register(asc_pkg::REG_NOISE_LIMIT, nl);
    write_register(asc_pkg::REG_PEAK_THRESH, thr);
    write_register(asc_pkg::REG_LEVEL, {pad, lvl});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] draw_sample(input asc_pkg::class_t c);
    int lo;
    int hi;
    int m;
    lo = (noise_lim > 1) ? int'(noise_lim) : 1;
    hi = int'(peak_thr) - 1;
    case (c)
      asc_pkg::CL_NOISE:
        if (noise_lim != 0) begin
          m = $urandom_range(noise_lim - 1, 0);
          return SB'($urandom_range(1) ? -m : m);
        end
      asc_pkg::CL_HIGH:
        if (lo <= hi) return SB'(int'($urandom_range(hi, lo)));
      asc_pkg::CL_LOW:
        if (lo <= hi) return SB'(-int'($urandom_range(hi, lo)));
      default: begin
        if (int'(peak_thr) > lo) lo = int'(peak_thr);
        m = $urandom_range(MAX_POS, lo);
        return SB'($urandom_range(1) ? -m : m);
      end
    endcase
    return SB'($urandom);
  endfunction

  task automatic test_pass_through_defaults();
    send_sample(16'sh7fff, 2'd3);
    send_sample(16'sh8000, 2'd2);
    send_sample(16'sh0000, 2'd1);
    send_sample(16'sh0001, 2'd0);
    send_sample(-16'sd1, 2'd3);
  endtask

  task automatic test_spike_runs();
    apply_settings(15'd100, 15'd1000, asc_pkg::LEVEL_FOUR, 12'd0);
    send_sample(16'sd500, 2'd1);
    send_sample(16'sd10, 2'd0);
    send_sample(-16'sd500, 2'd2);
    send_sample(-16'sd500, 2'd3);
    repeat (3) send_sample(16'sd300, 2'd1);
    send_sample(-16'sd10, 2'd0);
    repeat (4) send_sample(16'sd400, 2'd2);
    send_sample(16'sd5000, 2'd3);
    send_sample(16'sd10, 2'd0);
  endtask

  task automatic test_saturation();
    apply_settings(15'h7fff, 15'h7fff, asc_pkg::LEVEL_THREE, 12'd0);
    send_sample(16'sh8000, 2'd1);
    send_sample(16'sd32766, 2'd2);
    send_sample(-16'sd32767, 2'd3);
  endtask

  task automatic test_level_limits();
    apply_settings(15'd100, 15'd1000, LEVEL_ZERO, 12'd0);
    send_sample(16'sd500, 2'd1);
    send_sample(16'sd20, 2'd2);
    apply_settings(15'd100, 15'd1000, LEVEL_MAX, 12'hfff);
    send_sample(-16'sd700, 2'd3);
    wait_idle();
    write_register(REG_UNUSED, 15'h7fff);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(16'sd0, 2'd0);
  endtask

  task automatic test_random_streams();
    int     nl[10]  = '{0, 200, 50, 1000, 32767, 0, 500, 3, 0, 0};
    int     thr[10] = '{0, 3000, 800, 20000, 32767, 32767, 400, 32767, 0, 0};
    logic [2:0] lvl[10] = '{asc_pkg::LEVEL_RESET, asc_pkg::LEVEL_FOUR, asc_pkg::LEVEL_THREE,
                            asc_pkg::LEVEL_TWO, LEVEL_MAX, LEVEL_ZERO, LEVEL_FIVE,
                            LEVEL_SIX, LEVEL_ZERO, LEVEL_ZERO};
    int     sent;
    int     pick;
    int     run_len;
    asc_pkg::class_t c;
    for (int p = 0; p < 10; p++) begin
      if (p >= 8) begin
        nl[p] = $urandom_range(2000, 0);
        thr[p] = $urandom_range(32767, 0);
        lvl[p] = 3'($urandom_range(7, 0));
      end
      apply_settings(15'(nl[p]), 15'(thr[p]), lvl[p], 12'($urandom));
      calm = (p == 3);
      sent = 0;
      while (sent < 190) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          send_sample(SB'($urandom), 2'($urandom));
          sent++;
        end else begin
          c = (pick < 40) ? asc_pkg::CL_NOISE : (pick < 65) ? asc_pkg::CL_HIGH :
              (pick < 90) ? asc_pkg::CL_LOW : asc_pkg::CL_OTHER;
          run_len = $urandom_range(5, 1);
          repeat (run_len) begin
            send_sample(draw_sample(c), 2'($urandom));
            sent++;
          end
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    clear_canceller();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pass_through_defaults();
    test_spike_runs();
    test_saturation();
    test_level_limits();
    test_random_streams();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> adc_spike_canceller_top.f
sv/asc_pkg.sv
sv/adc_spike_canceller_top.sv
sv/adc_spike_canceller_checker.sv
sim/adc_spike_canceller_top_test.sv
